// File: rtl/core/mcpt_pkg.sv
// mcpt_pkg: shared constants and types of the multi-channel pulse timer
// used by mcpt_channel and multi_channel_four_phase_pulse_timer_core
// no dependencies
package mcpt_pkg;

  localparam int CHANNELS = 8;
  localparam int PHASES   = 4;
  localparam int PH_W     = $clog2(PHASES);
  localparam int DUR_W    = 16;
  localparam int CH_W     = 3;
  localparam int LVL_W    = 8;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [PH_W-1:0] PHASE_FIRST      = '0;
  localparam logic [PH_W-1:0] PHASE_PREV_RESET = PH_W'(PHASES - 1);

  typedef logic [DUR_W-1:0] dur_t;
  typedef logic [PH_W-1:0]  phase_t;

  typedef struct packed {
    logic   tick;
    logic   load;
    phase_t phase;
    dur_t   duration;
  } chan_ctrl_t;

endpackage

// File: rtl/core/mcpt_channel.sv
// mcpt_channel: one timer channel with its phase duration table and counter
// depends on mcpt_pkg
module mcpt_channel (
  input  logic                clk,
  input  logic                rst_n,
  input  mcpt_pkg::chan_ctrl_t ctrl,
  output logic                level,
  output logic                level_nxt
);
  import mcpt_pkg::*;

  dur_t   tbl_r [PHASES];
  dur_t   tbl_nxt [PHASES];
  dur_t   cnt_r, cnt_nxt;
  phase_t cur_r, cur_nxt;
  phase_t prev_r, prev_nxt;
  logic   lvl_r, lvl_nxt;

  dur_t   base;
  dur_t   dec;
  logic   done;

  always_comb begin
    base = (prev_r != cur_r) ? tbl_r[cur_r] : cnt_r;
    dec  = base - dur_t'(1);
    done = (dec == '0);

    tbl_nxt  = tbl_r;
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    lvl_nxt  = lvl_r;

    if (ctrl.load) begin
      tbl_nxt[ctrl.phase] = ctrl.duration;
    end
    if (ctrl.tick) begin
      cnt_nxt  = dec;
      prev_nxt = cur_r;
      if (done) begin
        // end of an even phase clears the output, odd phase sets it
        lvl_nxt = cur_r[0];
        cur_nxt = cur_r + phase_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PHASES; p++) begin
        tbl_r[p] <= '0;
      end
      cnt_r  <= '0;
      cur_r  <= PHASE_FIRST;
      prev_r <= PHASE_PREV_RESET;
      lvl_r  <= 1'b0;
    end else begin
      tbl_r  <= tbl_nxt;
      cnt_r  <= cnt_nxt;
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
      lvl_r  <= lvl_nxt;
    end
  end

  assign level     = lvl_r;
  assign level_nxt = lvl_nxt;

endmodule

// File: rtl/core/multi_channel_four_phase_pulse_timer_core.sv
// multi_channel_four_phase_pulse_timer_core: top level of the pulse timer
// depends on mcpt_pkg and mcpt_channel
//
// Eight channels each step through four phases with a programmable 16-bit
// duration per phase (0 means 65536 ticks). A load request writes one
// duration word; a tick request advances every channel in parallel. Each
// request yields exactly one result carrying all channel output levels after
// the request took effect. A request is registered on entry and its result
// is registered on exit, and one request is taken every cycle while the
// result side keeps up; the per-channel decrement and compare is the only
// logic between the two registers. The duration table is cleared by reset.
module multi_channel_four_phase_pulse_timer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [mcpt_pkg::CH_W-1:0]   in_channel,
  input  logic [mcpt_pkg::PH_W-1:0]   in_phase,
  input  logic [mcpt_pkg::DUR_W-1:0]  in_duration,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcpt_pkg::LVL_W-1:0]  out_levels
);
  import mcpt_pkg::*;

  logic             in_valid_r;
  logic             in_kind_r;
  logic [CH_W-1:0]  in_channel_r;
  phase_t           in_phase_r;
  dur_t             in_duration_r;
  logic             out_valid_r;
  logic [LVL_W-1:0] out_levels_r;

  logic             adv;
  logic             go;
  logic [CHANNELS-1:0] lvl;
  logic [CHANNELS-1:0] lvl_nxt;
  logic [LVL_W-1:0]    lvl_view;
  logic [LVL_W-1:0]    lvl_nxt_view;

  assign adv      = !out_valid_r || !out_stall;
  assign go       = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_kind_r     <= in_kind;
      in_channel_r  <= in_channel;
      in_phase_r    <= in_phase;
      in_duration_r <= in_duration;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    chan_ctrl_t ctrl;
    logic       sel;

    if (i < (1 << CH_W)) begin : g_sel
      assign sel = (in_channel_r == CH_W'(i));
    end else begin : g_nosel
      assign sel = 1'b0;
    end

    assign ctrl.tick     = go && (in_kind_r == KIND_TICK);
    assign ctrl.load     = go && (in_kind_r == KIND_LOAD) && sel;
    assign ctrl.phase    = in_phase_r;
    assign ctrl.duration = in_duration_r;

    mcpt_channel u_ch (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .level     (lvl[i]),
      .level_nxt (lvl_nxt[i])
    );
  end

  for (genvar b = 0; b < LVL_W; b++) begin : g_view
    if (b < CHANNELS) begin : g_live
      assign lvl_view[b]     = lvl[b];
      assign lvl_nxt_view[b] = lvl_nxt[b];
    end else begin : g_pad
      assign lvl_view[b]     = 1'b0;
      assign lvl_nxt_view[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_levels_r <= lvl_nxt_view;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_levels = out_levels_r;

  a_load_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
    go && (in_kind_r == KIND_LOAD) |=> lvl_view == $past(lvl_view))
    else $error("load request changed output levels");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with free pipeline");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid && out_levels == $past(lvl_nxt_view))
    else $error("request did not produce its result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_levels == lvl_view)
    else $error("result differs from channel levels");

endmodule

// File: sim/mcpt_checker.sv
`timescale 1ns / 100ps
// mcpt_checker: predicts the output levels of the pulse timer core for every
// accepted request and compares them with the results seen on the out channel
// depends on mcpt_pkg
module mcpt_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_kind,
  input  logic [mcpt_pkg::CH_W-1:0]   in_channel,
  input  logic [mcpt_pkg::PH_W-1:0]   in_phase,
  input  logic [mcpt_pkg::DUR_W-1:0]  in_duration,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [mcpt_pkg::LVL_W-1:0]  out_levels,
  output int                          mismatches,
  output int                          pending
);
  import mcpt_pkg::*;

  dur_t                phase_len  [CHANNELS][PHASES];
  dur_t                remaining  [CHANNELS];
  phase_t              cur_phase  [CHANNELS];
  phase_t              last_phase [CHANNELS];
  logic [CHANNELS-1:0] levels;
  logic [LVL_W-1:0]    levels_due [$];

  task automatic clear_timers();
    for (int c = 0; c < CHANNELS; c++) begin
      for (int p = 0; p < PHASES; p++) begin
        phase_len[c][p] = '0;
      end
      remaining[c]  = '0;
      cur_phase[c]  = PHASE_FIRST;
      last_phase[c] = PHASE_PREV_RESET;
    end
    levels = '0;
    levels_due.delete();
  endtask

  function automatic logic [LVL_W-1:0] apply_request(logic kind, logic [CH_W-1:0] ch,
                                                     phase_t ph, dur_t dur);
    if (kind == KIND_LOAD) begin
      if (int'(ch) < CHANNELS) begin
        phase_len[ch][ph] = dur;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (last_phase[c] != cur_phase[c]) begin
          remaining[c] = phase_len[c][cur_phase[c]];
        end
        last_phase[c] = cur_phase[c];
        remaining[c]  = remaining[c] - 1'b1;
        if (remaining[c] == '0) begin
          // even phases end low, odd phases end high
          levels[c]    = cur_phase[c][0];
          cur_phase[c] = cur_phase[c] + 1'b1;
        end
      end
    end
    return LVL_W'(levels);
  endfunction

  task automatic report_mismatch(string what, logic [LVL_W-1:0] got, logic [LVL_W-1:0] want);
    $display("%0t mismatch: %s, out_levels got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    logic [LVL_W-1:0] want;
    if (!rst_n) begin
      clear_timers();
    end else begin
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          report_mismatch("result with no request pending", out_levels, 'x);
        end else begin
          want = levels_due.pop_front();
          if (out_levels !== want) begin
            report_mismatch("wrong levels", out_levels, want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        levels_due.push_back(apply_request(in_kind, in_channel, in_phase, in_duration));
      end
    end
    pending = levels_due.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: request stimulus, result back-pressure and verdict for the pulse timer core
// depends on mcpt_pkg, multi_channel_four_phase_pulse_timer_core and mcpt_checker
module tb_top;
  import mcpt_pkg::*;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int QUIET_FROM      = 1450;
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 10;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_kind     = KIND_TICK;
  logic [CH_W-1:0]  in_channel  = '0;
  phase_t           in_phase    = '0;
  dur_t             in_duration = '0;
  logic             out_stall   = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [LVL_W-1:0] out_levels;

  int mismatches;
  int pending;
  int requests_sent = 0;
  int idle_cycles   = 0;
  bit quiet         = 1'b0;
  bit hold_done     = 1'b0;

  always #5 clk = ~clk;

  multi_channel_four_phase_pulse_timer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_channel  (in_channel),
    .in_phase    (in_phase),
    .in_duration (in_duration),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_levels  (out_levels)
  );

  mcpt_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_channel  (in_channel),
    .in_phase    (in_phase),
    .in_duration (in_duration),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_levels  (out_levels),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("multi_channel_four_phase_pulse_timer_core test failed");
    $finish;
  end

  function automatic dur_t pick_duration();
    if ($urandom_range(0, 199) == 0) begin
      return dur_t'($urandom);
    end
    return dur_t'($urandom_range(1, 12));
  endfunction

  task automatic send_request(logic kind, logic [CH_W-1:0] ch, phase_t ph, dur_t dur);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind     = kind;
    in_channel  = ch;
    in_phase    = ph;
    in_duration = dur;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
  endtask

  // result side back-pressure, with one long hold-off to fill the core
  initial begin
    int stall_len;
    forever begin
      @(negedge clk);
      if (!hold_done && requests_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_len = $urandom_range(1, 5);
        out_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // program every phase of every channel before the first tick
    // channel 6 phase 2 keeps a zero duration, so it wraps to 65536 ticks
    for (int c = 0; c < CHANNELS; c++) begin
      for (int p = 0; p < PHASES; p++) begin
        if (c == 6 && p == 2) begin
          send_request(KIND_LOAD, CH_W'(c), PH_W'(p), 16'h0000);
        end else begin
          send_request(KIND_LOAD, CH_W'(c), PH_W'(p), dur_t'($urandom_range(1, 6)));
        end
      end
    end

    // largest nonzero duration, then overwritten before it is reached
    send_request(KIND_LOAD, 3'd5, 2'd1, 16'hFFFF);
    send_request(KIND_LOAD, 3'd5, 2'd1, 16'h0002);
    // channel 0 ends a phase on every tick
    send_request(KIND_LOAD, 3'd0, 2'd0, 16'h0001);
    send_request(KIND_LOAD, 3'd0, 2'd1, 16'h0001);
    send_request(KIND_LOAD, 3'd0, 2'd2, 16'h0001);
    send_request(KIND_LOAD, 3'd0, 2'd3, 16'h0001);
    // first tick reloads every counter
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    send_request(KIND_TICK, 3'd7, 2'd3, 16'hFFFF);
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    // load while running leaves the levels alone
    send_request(KIND_LOAD, 3'd7, 2'd3, 16'h0001);
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    send_request(KIND_TICK, 3'd0, 2'd0, 16'h0000);
    send_request(KIND_TICK, 3'd7, 2'd3, 16'hFFFF);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i >= QUIET_FROM) begin
        quiet = 1'b1;
      end
      if ($urandom_range(0, 9) < 3) begin
        send_request(KIND_LOAD, CH_W'($urandom_range(0, CHANNELS - 1)),
                     PH_W'($urandom_range(0, PHASES - 1)), pick_duration());
      end else begin
        send_request(KIND_TICK, CH_W'($urandom), PH_W'($urandom), dur_t'($urandom));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("multi_channel_four_phase_pulse_timer_core test passed");
    end else begin
      $display("multi_channel_four_phase_pulse_timer_core test failed");
    end
    $finish;
  end

endmodule
